// ===== rtl/tbd_pkg.sv =====
// Shared widths, register indexes and sequencer states for the time bucket downsampler.
package tbd_pkg;

	localparam int TIME_W     = 32;
	localparam int VALUE_W    = 32;
	localparam int STATE_W    = 3;
	localparam int CFG_W      = 13;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int PROD_W     = TIME_W + CFG_W;

	localparam logic [CFG_W-1:0] STEP_LIMIT = 13'h1FFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OLDEST_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_SPAN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT  = 2'd3;

	// sequencer states, one-hot
	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_CHECK  = 11'b000_0000_0010,
		S_MULA   = 11'b000_0000_0100,
		S_MULB   = 11'b000_0000_1000,
		S_DECIDE = 11'b000_0001_0000,
		S_TGO    = 11'b000_0010_0000,
		S_TWAIT  = 11'b000_0100_0000,
		S_VGO    = 11'b000_1000_0000,
		S_VWAIT  = 11'b001_0000_0000,
		S_EMIT   = 11'b010_0000_0000,
		S_ACC    = 11'b100_0000_0000
	} seq_state_t;

endpackage

// ===== rtl/time_bucket_downsampler_unit.sv =====
// Top level: time bucket averaging downsampler with a small sequencer and shared units.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------------
//  input   | in        | in_valid / in_stall | sample_time, sample_value, sample_state, sample_last
//  output  | out       | out_valid/out_stall | point_time, point_value, point_state, point_final
//  config  | in        | cfg_we              | cfg_index, cfg_data
//
// One item at a time. A pass-through item goes through the check and emit steps. An averaged item that
// closes no bucket passes check, both multiplies, decide and accumulate (check and accumulate when it opens
// one); each emitted point adds two serial divisions, for the time mean and then the value mean, on the
// one-bit-per-cycle divider shared by both means.
// Reset clears the sequencer and accumulators and sets the configuration registers to their reset values.
// A stalled output holds the sequencer in its emit step; in_stall is high while busy.
module time_bucket_downsampler_unit #(
	parameter int MAX_ITEMS = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tbd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tbd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [tbd_pkg::TIME_W-1:0]            sample_time,
	input  logic signed [tbd_pkg::VALUE_W-1:0]    sample_value,
	input  logic [tbd_pkg::STATE_W-1:0]           sample_state,
	input  logic                                  sample_last,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [tbd_pkg::TIME_W-1:0]            point_time,
	output logic signed [tbd_pkg::VALUE_W-1:0]    point_value,
	output logic [tbd_pkg::STATE_W-1:0]           point_state,
	output logic                                  point_final
);

	localparam int LG = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int DW = tbd_pkg::TIME_W + LG;

	tbd_pkg::seq_state_t state_q;

	// configuration registers
	logic [tbd_pkg::TIME_W-1:0] oldest_time_q;
	logic [tbd_pkg::TIME_W-1:0] time_span_q;
	logic [tbd_pkg::CFG_W-1:0]  max_points_q;
	logic [tbd_pkg::CFG_W-1:0]  item_count_q;

	// run state
	logic [DW-1:0]               time_sum_q;
	logic signed [DW-1:0]        value_sum_q;
	logic [CW-1:0]               bucket_count_q;
	logic [tbd_pkg::STATE_W-1:0] bucket_state_q;
	logic [tbd_pkg::CFG_W-1:0]   step_index_q;

	// latched item and working registers
	logic [tbd_pkg::TIME_W-1:0]        s_time_q;
	logic signed [tbd_pkg::VALUE_W-1:0] s_value_q;
	logic [tbd_pkg::STATE_W-1:0]       s_state_q;
	logic                              s_last_q;
	logic [tbd_pkg::TIME_W-1:0]        tdiff_q;
	logic [tbd_pkg::PROD_W-1:0]        lhs_q;
	logic [tbd_pkg::PROD_W-1:0]        rhs_q;
	logic                              pass_q;
	logic                              final_q;
	logic                              neg_q;
	logic [tbd_pkg::TIME_W-1:0]        qt_q;
	logic [tbd_pkg::VALUE_W-1:0]       qv_q;

	// output register
	logic                              out_valid_q;
	logic [tbd_pkg::TIME_W-1:0]        point_time_q;
	logic [tbd_pkg::VALUE_W-1:0]       point_value_q;
	logic [tbd_pkg::STATE_W-1:0]       point_state_q;
	logic                              point_final_q;

	logic                              in_acc;
	logic                              out_free;
	logic                              close_bucket;
	logic [tbd_pkg::TIME_W-1:0]        mul_a;
	logic [tbd_pkg::CFG_W-1:0]         mul_b;
	logic [tbd_pkg::PROD_W-1:0]        product;
	logic                              div_start;
	logic [DW-1:0]                     div_dividend;
	logic [DW-1:0]                     div_quot;
	logic                              div_done;
	logic [DW-1:0]                     value_mag;
	logic [DW-1:0]                     quot_signed;

	assign in_stall = state_q != tbd_pkg::S_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// shared multiplier: crossing side first, then span side
	assign mul_a   = (state_q == tbd_pkg::S_MULA) ? tdiff_q : time_span_q;
	assign mul_b   = (state_q == tbd_pkg::S_MULA) ? max_points_q : step_index_q;
	assign product = tbd_pkg::PROD_W'(mul_a) * tbd_pkg::PROD_W'(mul_b);

	assign close_bucket = (lhs_q > rhs_q) || (bucket_count_q >= CW'(MAX_ITEMS))
		|| (s_state_q != bucket_state_q);

	// divider operand select
	assign value_mag    = value_sum_q[DW-1] ? DW'(-value_sum_q) : DW'(value_sum_q);
	assign div_start    = (state_q == tbd_pkg::S_TGO) || (state_q == tbd_pkg::S_VGO);
	assign div_dividend = (state_q == tbd_pkg::S_VGO) ? value_mag : time_sum_q;
	assign quot_signed  = neg_q ? (~div_quot + DW'(1)) : div_quot;

	tbd_div #(
		.DW(DW),
		.NW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (bucket_count_q),
		.quotient (div_quot),
		.done     (div_done)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_time_q <= '0;
			time_span_q   <= '0;
			max_points_q  <= tbd_pkg::CFG_W'(128);
			item_count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tbd_pkg::REG_OLDEST_TIME: oldest_time_q <= cfg_data;
				tbd_pkg::REG_TIME_SPAN:   time_span_q   <= cfg_data;
				tbd_pkg::REG_MAX_POINTS:  max_points_q  <= cfg_data[tbd_pkg::CFG_W-1:0];
				tbd_pkg::REG_ITEM_COUNT:  item_count_q  <= cfg_data[tbd_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tbd_pkg::S_IDLE;
			time_sum_q     <= '0;
			value_sum_q    <= '0;
			bucket_count_q <= '0;
			bucket_state_q <= '0;
			step_index_q   <= tbd_pkg::CFG_W'(1);
			pass_q         <= 1'b0;
			final_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// output valid: set on a new point, cleared once taken
			if ((state_q == tbd_pkg::S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tbd_pkg::S_IDLE: begin
					if (in_acc) begin
						state_q <= tbd_pkg::S_CHECK;
					end
				end
				tbd_pkg::S_CHECK: begin
					final_q <= 1'b0;
					if (item_count_q < max_points_q) begin
						pass_q  <= 1'b1;
						state_q <= tbd_pkg::S_EMIT;
					end else if (bucket_count_q == '0) begin
						pass_q         <= 1'b0;
						bucket_state_q <= s_state_q;
						state_q        <= tbd_pkg::S_ACC;
					end else begin
						pass_q  <= 1'b0;
						state_q <= tbd_pkg::S_MULA;
					end
				end
				tbd_pkg::S_MULA: begin
					state_q <= tbd_pkg::S_MULB;
				end
				tbd_pkg::S_MULB: begin
					state_q <= tbd_pkg::S_DECIDE;
				end
				tbd_pkg::S_DECIDE: begin
					state_q <= close_bucket ? tbd_pkg::S_TGO : tbd_pkg::S_ACC;
				end
				tbd_pkg::S_TGO: begin
					state_q <= tbd_pkg::S_TWAIT;
				end
				tbd_pkg::S_TWAIT: begin
					if (div_done) begin
						state_q <= tbd_pkg::S_VGO;
					end
				end
				tbd_pkg::S_VGO: begin
					state_q <= tbd_pkg::S_VWAIT;
				end
				tbd_pkg::S_VWAIT: begin
					if (div_done) begin
						state_q <= tbd_pkg::S_EMIT;
					end
				end
				tbd_pkg::S_EMIT: begin
					if (out_free) begin
						if (pass_q || final_q) begin
							// run end after a last item; pass-through keeps the run otherwise
							if (!pass_q || s_last_q) begin
								time_sum_q     <= '0;
								value_sum_q    <= '0;
								bucket_count_q <= '0;
								bucket_state_q <= '0;
								step_index_q   <= tbd_pkg::CFG_W'(1);
							end
							state_q <= tbd_pkg::S_IDLE;
						end else begin
							// closed bucket: start a new one with this item
							if (step_index_q < tbd_pkg::STEP_LIMIT) begin
								step_index_q <= step_index_q + tbd_pkg::CFG_W'(1);
							end
							time_sum_q     <= '0;
							value_sum_q    <= '0;
							bucket_count_q <= '0;
							bucket_state_q <= s_state_q;
							state_q        <= tbd_pkg::S_ACC;
						end
					end
				end
				tbd_pkg::S_ACC: begin
					time_sum_q     <= time_sum_q + DW'(s_time_q);
					value_sum_q    <= value_sum_q + DW'(s_value_q);
					bucket_count_q <= bucket_count_q + CW'(1);
					if (s_last_q) begin
						final_q <= 1'b1;
						state_q <= tbd_pkg::S_TGO;
					end else begin
						state_q <= tbd_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= tbd_pkg::S_IDLE;
				end
			endcase
		end
	end

	// item latch, products and quotients
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_time_q  <= sample_time;
			s_value_q <= sample_value;
			s_state_q <= sample_state;
			s_last_q  <= sample_last;
		end
		if (state_q == tbd_pkg::S_CHECK) begin
			// a time before the oldest never crosses
			tdiff_q <= (s_time_q >= oldest_time_q) ? (s_time_q - oldest_time_q) : '0;
		end
		if (state_q == tbd_pkg::S_MULA) begin
			lhs_q <= product;
		end
		if (state_q == tbd_pkg::S_MULB) begin
			rhs_q <= product;
		end
		if (state_q == tbd_pkg::S_VGO) begin
			neg_q <= value_sum_q[DW-1];
		end
		if ((state_q == tbd_pkg::S_TWAIT) && div_done) begin
			qt_q <= div_quot[tbd_pkg::TIME_W-1:0];
		end
		if ((state_q == tbd_pkg::S_VWAIT) && div_done) begin
			qv_q <= quot_signed[tbd_pkg::VALUE_W-1:0];
		end
		if ((state_q == tbd_pkg::S_EMIT) && out_free) begin
			if (pass_q) begin
				point_time_q  <= s_time_q;
				point_value_q <= s_value_q;
				point_state_q <= s_state_q;
				point_final_q <= s_last_q;
			end else begin
				point_time_q  <= qt_q;
				point_value_q <= qv_q;
				point_state_q <= bucket_state_q;
				point_final_q <= final_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign point_time  = point_time_q;
	assign point_value = point_value_q;
	assign point_state = point_state_q;
	assign point_final = point_final_q;

endmodule

// ===== rtl/tbd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, shared by both means.
module tbd_div #(
	parameter int DW = 44,
	parameter int NW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    dvd_q;
	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [NW:0]      trial;
	logic [NW:0]      diff;
	logic             ge;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done pulses for one cycle after the last quotient bit
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: quotient bits shift in at the bottom of the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule
